### sv/tesan_pkg.sv
package tesan_pkg;

   localparam int unsigned BURST_MAX = 4;

   // bytes released by one input word, lowest index goes out first
   typedef struct packed {
      logic [BURST_MAX-1:0][7:0] bytes;
      logic [2:0]                len;    // 1..4
   } burst_type;

endpackage

### sv/tesan_front.sv
module tesan_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   output logic                 push,
   output tesan_pkg::burst_type burst
);
   import tesan_pkg::*;

   localparam logic [2:0] MODE_NORMAL  = 3'd0;
   localparam logic [2:0] MODE_ESC     = 3'd1;
   localparam logic [2:0] MODE_CSI     = 3'd2;
   localparam logic [2:0] MODE_STRING  = 3'd3;
   localparam logic [2:0] MODE_STR_ESC = 3'd4;
   localparam logic [2:0] MODE_SKIP    = 3'd5;

   localparam logic [7:0] CH_BEL = 8'h07;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CAN = 8'h18;
   localparam logic [7:0] CH_SUB = 8'h1A;
   localparam logic [7:0] CH_ESC = 8'h1B;
   localparam logic [7:0] CH_DEL = 8'h7F;
   localparam logic [7:0] CH_ST  = 8'h9C;

   logic [2:0]       mode_ff, mode_in;
   logic [1:0]       rem_ff, rem_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic [20:0]      val_ff, val_in;
   logic [2:0][7:0]  held_ff, held_in;

   logic [20:0]      val_nx;
   logic [2:0]       cnt_nx;
   logic [20:0]      cp_lo;
   logic             len_ok;
   logic             cp_ok;
   logic             fresh;

   function automatic logic [2:0] c1_next(input logic [2:0] m, input logic [7:0] code);
      logic [2:0] r;
      r = MODE_NORMAL;
      if (m == MODE_STRING || m == MODE_STR_ESC) begin
         r = (code == CH_ST) ? MODE_NORMAL : MODE_STRING;
      end else begin
         case (code) inside
            8'h9B:                      r = MODE_CSI;
            8'h90, 8'h9D, 8'h9E, 8'h9F: r = MODE_STRING;
            8'h8E, 8'h8F:               r = MODE_SKIP;
            default:                    r = MODE_NORMAL;
         endcase
      end
      return r;
   endfunction

   always_comb begin
      mode_in = mode_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      held_in = held_ff;
      push    = 1'b0;
      burst   = '0;
      fresh   = 1'b1;
      val_nx  = {val_ff[14:0], in_byte[5:0]};
      cnt_nx  = cnt_ff + 3'd1;
      len_ok  = 1'b1;
      unique case (cnt_nx)
         3'd2:    cp_lo = 21'h000080;
         3'd3:    cp_lo = 21'h000800;
         3'd4:    cp_lo = 21'h010000;
         default: begin
            cp_lo  = 21'h000000;
            len_ok = 1'b0;
         end
      endcase
      cp_ok = len_ok && (val_nx >= cp_lo)
           && !(val_nx >= 21'h00D800 && val_nx <= 21'h00DFFF)
           && (val_nx <= 21'h10FFFF);

      if (accept) begin
         if (rem_ff != 2'd0) begin
            if (in_byte < 8'h80 || in_byte > 8'hBF) begin
               // broken sequence: drop it, reprocess this byte below
               rem_in = 2'd0;
               cnt_in = 3'd0;
               val_in = '0;
            end else if (cnt_ff >= 3'd4) begin
               rem_in = 2'd0;
               cnt_in = 3'd0;
               val_in = '0;
               fresh  = 1'b0;
            end else begin
               fresh = 1'b0;
               if (cnt_ff < 3'd3) begin
                  held_in[cnt_ff[1:0]] = in_byte;
               end
               if (rem_ff != 2'd1) begin
                  rem_in = rem_ff - 2'd1;
                  cnt_in = cnt_nx;
                  val_in = val_nx;
               end else begin
                  rem_in = 2'd0;
                  cnt_in = 3'd0;
                  val_in = '0;
                  if (cp_ok) begin
                     if (val_nx >= 21'h000080 && val_nx <= 21'h00009F) begin
                        mode_in = c1_next(mode_ff, val_nx[7:0]);
                     end else begin
                        push           = 1'b1;
                        burst.len      = cnt_nx;
                        burst.bytes[0] = held_ff[0];
                        burst.bytes[1] = held_ff[1];
                        burst.bytes[2] = held_ff[2];
                        burst.bytes[cnt_ff[1:0]] = in_byte;
                     end
                  end
               end
            end
         end

         if (fresh) begin
            if (mode_ff == MODE_NORMAL && in_byte >= 8'h80) begin
               if (in_byte <= 8'h9F) begin
                  mode_in = c1_next(mode_ff, in_byte);
               end else if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
                  rem_in     = 2'd1;
                  cnt_in     = 3'd1;
                  val_in     = {16'd0, in_byte[4:0]};
                  held_in[0] = in_byte;
               end else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) begin
                  rem_in     = 2'd2;
                  cnt_in     = 3'd1;
                  val_in     = {17'd0, in_byte[3:0]};
                  held_in[0] = in_byte;
               end else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) begin
                  rem_in     = 2'd3;
                  cnt_in     = 3'd1;
                  val_in     = {18'd0, in_byte[2:0]};
                  held_in[0] = in_byte;
               end
            end else if (mode_ff == MODE_SKIP) begin
               mode_in = MODE_NORMAL;
            end else begin
               burst.len      = 3'd1;
               burst.bytes[0] = in_byte;
               case (in_byte) inside
                  CH_CAN, CH_SUB: mode_in = MODE_NORMAL;
                  CH_ESC: begin
                     mode_in = (mode_ff == MODE_STRING || mode_ff == MODE_STR_ESC)
                             ? MODE_STR_ESC : MODE_ESC;
                  end
                  CH_BEL: begin
                     if (mode_ff == MODE_STRING || mode_ff == MODE_STR_ESC) begin
                        mode_in = MODE_NORMAL;
                     end
                  end
                  CH_LF, CH_TAB: push = (mode_ff == MODE_NORMAL);
                  CH_DEL: ;
                  default: begin
                     if (in_byte < 8'h20) begin
                        // other C0 controls vanish
                     end else if (in_byte >= 8'h80 && in_byte <= 8'h9F) begin
                        mode_in = c1_next(mode_ff, in_byte);
                     end else begin
                        unique case (mode_ff)
                           MODE_ESC: begin
                              case (in_byte) inside
                                 8'h5B:                      mode_in = MODE_CSI;
                                 8'h5D, 8'h50, 8'h5E, 8'h5F: mode_in = MODE_STRING;
                                 8'h4E, 8'h4F, 8'h23, 8'h25, 8'h20, 8'h28, 8'h29,
                                 8'h2A, 8'h2B, 8'h2D, 8'h2E, 8'h2F:
                                    mode_in = MODE_SKIP;
                                 default:                    mode_in = MODE_NORMAL;
                              endcase
                           end
                           MODE_CSI: begin
                              if (in_byte >= 8'h40 && in_byte <= 8'h7E) begin
                                 mode_in = MODE_NORMAL;
                              end
                           end
                           MODE_STRING: ;
                           MODE_STR_ESC: begin
                              mode_in = (in_byte == 8'h5C) ? MODE_NORMAL : MODE_STRING;
                           end
                           default: push = 1'b1;
                        endcase
                     end
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         rem_ff  <= 2'd0;
         cnt_ff  <= 3'd0;
         val_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         rem_ff  <= rem_in;
         cnt_ff  <= cnt_in;
         val_ff  <= val_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

### sv/tesan_queue.sv
module tesan_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tesan_pkg::burst_type push_data,
   input  logic                 pop,
   output tesan_pkg::burst_type head,
   output logic                 empty,
   output logic                 full
);
   import tesan_pkg::*;

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

   burst_type         store_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(DEPTH));
   assign head  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/tesan_back.sv
module tesan_back (
   input  logic                 clock,
   input  logic                 reset,
   input  tesan_pkg::burst_type head,
   input  logic                 empty,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [7:0]           out_byte,
   output logic                 out_last
);
   import tesan_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       taken;

   assign out_valid = !empty;
   assign out_byte  = head.bytes[idx_ff];
   assign out_last  = ({1'b0, idx_ff} == head.len - 3'd1);
   assign taken     = out_valid && out_ready;
   assign pop       = taken && out_last;

   always_comb begin
      idx_in = idx_ff;
      if (taken) begin
         idx_in = out_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

### sv/terminal_escape_utf8_sanitizer.sv
// channel  dir  handshake              payload
// req_     in   req_tvalid/req_tready  tdata[7:0] in_byte
// rsp_     out  rsp_tvalid/rsp_tready  tdata[7:0] out_byte, tlast run_last
//
// One word is taken per cycle while the burst queue has room; the classifier
// settles each byte in that cycle. Each byte releases 0 to 4 words, which the
// serializer sends one per cycle while rsp_tready is high, so output sets the sustained rate.
// Synchronous reset returns to plain text mode with an empty queue.
// A stalled output fills the queue (QUEUE_DEPTH bursts) before req_tready drops.
module terminal_escape_utf8_sanitizer #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // run_last
);
   import tesan_pkg::*;

   logic      accept;
   logic      push;
   burst_type burst;
   burst_type head;
   logic      empty;
   logic      full;
   logic      pop;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   tesan_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_tdata),
      .push    (push),
      .burst   (burst)
   );

   tesan_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (burst),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .full      (full)
   );

   tesan_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

### sim/tb_terminal_escape_utf8_sanitizer.sv
`timescale 1ns / 1ps

module tb_terminal_escape_utf8_sanitizer;

   localparam int GAP_MAX       = 18;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_ITEMS    = 40;
   localparam int RANDOM_ITEMS  = 350;
   localparam int CYCLE_LIMIT   = 300000;

   localparam logic [7:0] CH_BEL = 8'h07;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CAN = 8'h18;
   localparam logic [7:0] CH_SUB = 8'h1A;
   localparam logic [7:0] CH_ESC = 8'h1B;
   localparam logic [7:0] CH_BSL = 8'h5C;   // final byte of ESC-style ST
   localparam logic [7:0] CH_DEL = 8'h7F;
   localparam logic [7:0] C1_SS2 = 8'h8E;
   localparam logic [7:0] C1_SS3 = 8'h8F;
   localparam logic [7:0] C1_DCS = 8'h90;
   localparam logic [7:0] C1_CSI = 8'h9B;
   localparam logic [7:0] C1_ST  = 8'h9C;
   localparam logic [7:0] C1_OSC = 8'h9D;
   localparam logic [7:0] C1_PM  = 8'h9E;
   localparam logic [7:0] C1_APC = 8'h9F;

   typedef enum logic [2:0] {
      SCAN_TEXT, SCAN_ESC, SCAN_CSI, SCAN_STRING, SCAN_STR_ESC, SCAN_SKIP
   } scan_mode_type;

   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } text_word_type;

   typedef struct packed {
      logic [7:0]    data;
      row_check_type chk;
      logic [7:0]    out;
   } dir_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] in_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic       rsp_tlast;           // run_last

   // checking kind of the word on offer, travels with req_tdata
   row_check_type offer_chk = CHK_MODEL;
   logic [7:0]    offer_out = 8'h00;

   bit no_idle = 1'b0;
   bit hold_now = 1'b0;

   int fed = 0;
   int directed_count = 0;
   int words_checked = 0;
   int mismatches = 0;
   int cycle_count = 0;

   // sanitizer shadow state
   scan_mode_type p_mode;
   logic [1:0] p_left;
   logic [2:0] p_count;
   logic [20:0] p_cp;
   logic [7:0] p_held [3];

   text_word_type burst [$];
   text_word_type text_q [$];
   text_word_type due;
   dir_row_type   directed_rows [$];

   terminal_escape_utf8_sanitizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic void utf8_clear();
      p_left = 2'd0;
      p_count = 3'd0;
      p_cp = 21'd0;
      p_held[0] = 8'h00;
      p_held[1] = 8'h00;
      p_held[2] = 8'h00;
   endfunction

   function automatic bit in_str();
      return p_mode == SCAN_STRING || p_mode == SCAN_STR_ESC;
   endfunction

   function automatic void apply_c1(input logic [7:0] c);
      if (in_str()) begin
         p_mode = (c == C1_ST) ? SCAN_TEXT : SCAN_STRING;
         return;
      end
      case (c)
         C1_CSI: p_mode = SCAN_CSI;
         C1_DCS, C1_OSC, C1_PM, C1_APC: p_mode = SCAN_STRING;
         C1_SS2, C1_SS3: p_mode = SCAN_SKIP;
         default: p_mode = SCAN_TEXT;
      endcase
   endfunction

   function automatic bit cp_ok(input logic [20:0] cp, input int len);
      logic [20:0] lo;
      case (len)
         2: lo = 21'h80;
         3: lo = 21'h800;
         4: lo = 21'h10000;
         default: return 1'b0;
      endcase
      if (cp < lo) return 1'b0;
      if (cp >= 21'hD800 && cp <= 21'hDFFF) return 1'b0;
      return cp <= 21'h10FFFF;
   endfunction

   function automatic void utf8_start(input logic [7:0] c);
      if (c >= 8'hC2 && c <= 8'hDF) begin
         p_left = 2'd1;
         p_cp = {16'd0, c[4:0]};
      end else if (c >= 8'hE0 && c <= 8'hEF) begin
         p_left = 2'd2;
         p_cp = {17'd0, c[3:0]};
      end else if (c >= 8'hF0 && c <= 8'hF4) begin
         p_left = 2'd3;
         p_cp = {18'd0, c[2:0]};
      end else begin
         return;
      end
      p_count = 3'd1;
      p_held[0] = c;
   endfunction

   // control filter for one byte; -1 means dropped
   function automatic int scrub(input logic [7:0] c);
      if (p_mode == SCAN_SKIP) begin
         p_mode = SCAN_TEXT;
         return -1;
      end
      case (c)
         CH_CAN, CH_SUB: begin
            p_mode = SCAN_TEXT;
            return -1;
         end
         CH_ESC: begin
            p_mode = in_str() ? SCAN_STR_ESC : SCAN_ESC;
            return -1;
         end
         CH_BEL: begin
            if (in_str()) p_mode = SCAN_TEXT;
            return -1;
         end
         CH_LF, CH_TAB: return (p_mode == SCAN_TEXT) ? int'(c) : -1;
         CH_DEL: return -1;
         default: if (c < 8'h20) return -1;
      endcase
      if (c >= 8'h80 && c <= 8'h9F) begin
         apply_c1(c);
         return -1;
      end
      case (p_mode)
         SCAN_ESC: begin
            case (c)
               "[": p_mode = SCAN_CSI;
               "]", "P", "^", "_": p_mode = SCAN_STRING;
               "N", "O", "#", "%", " ", "(", ")", "*", "+", "-", ".", "/":
                  p_mode = SCAN_SKIP;
               default: p_mode = SCAN_TEXT;
            endcase
            return -1;
         end
         SCAN_CSI: begin
            if (c >= 8'h40 && c <= 8'h7E) p_mode = SCAN_TEXT;
            return -1;
         end
         SCAN_STRING: return -1;
         SCAN_STR_ESC: begin
            p_mode = (c == CH_BSL) ? SCAN_TEXT : SCAN_STRING;
            return -1;
         end
         default: return int'(c);
      endcase
   endfunction

   // clean text released by one raw byte, left in burst
   function automatic void sanitize(input logic [7:0] c);
      logic [7:0] run [4];
      int len;
      int r;
      logic [20:0] cp;
      burst.delete();
      if (p_left != 2'd0) begin
         if (c < 8'h80 || c > 8'hBF) begin
            utf8_clear();   // bad continuation, byte is handled fresh below
         end else if (p_count >= 3'd4) begin
            utf8_clear();
            return;
         end else begin
            if (p_count < 3'd3) p_held[p_count[1:0]] = c;
            p_count = p_count + 3'd1;
            p_cp = {p_cp[14:0], c[5:0]};
            p_left = p_left - 2'd1;
            if (p_left != 2'd0) return;
            len = int'(p_count);
            cp = p_cp;
            for (int k = 0; k + 1 < len && k < 3; k++) run[k] = p_held[k];
            run[(len - 1) & 3] = c;
            utf8_clear();
            if (!cp_ok(cp, len)) return;
            if (cp >= 21'h80 && cp <= 21'h9F) begin
               apply_c1(cp[7:0]);
               return;
            end
            for (int k = 0; k < len; k++) burst.push_back('{data: run[k], last: k == len - 1});
            return;
         end
      end
      if (p_mode == SCAN_TEXT && c >= 8'h80) begin
         if (c <= 8'h9F) apply_c1(c);
         else utf8_start(c);
         return;
      end
      r = scrub(c);
      if (r >= 0) burst.push_back('{data: r[7:0], last: 1'b1});
   endfunction

   // --------------------------------------------------------- monitor / check

   always @(posedge clock) begin
      if (reset) begin
         p_mode = SCAN_TEXT;
         utf8_clear();
         text_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            sanitize(req_tdata);
            case (offer_chk)
               CHK_MODEL: foreach (burst[i]) text_q.push_back(burst[i]);
               CHK_ONE: text_q.push_back('{data: offer_out, last: 1'b1});
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            words_checked++;
            if (text_q.size() == 0) begin
               $error("unexpected word: out_byte %h run_last %b", rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               due = text_q.pop_front();
               if (rsp_tdata !== due.data) begin
                  $error("out_byte: expected %h, actual %h", due.data, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tlast !== due.last) begin
                  $error("run_last: expected %b, actual %b", due.last, rsp_tlast);
                  mismatches++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------ sender

   task automatic send(input logic [7:0] d, input row_check_type chk, input logic [7:0] o);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      offer_chk <= chk;
      offer_out <= o;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      fed++;
   endtask

   task automatic feed(input logic [7:0] d);
      send(d, CHK_MODEL, 8'h00);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (text_q.size() != 0) @(posedge clock);
   endtask

   // encode cp in len bytes, send the first keep of them
   task automatic put_utf8(input logic [20:0] cp, input int len, input int keep);
      logic [7:0] ub [4];
      case (len)
         2: begin
            ub[0] = {3'b110, cp[10:6]};
            ub[1] = {2'b10, cp[5:0]};
         end
         3: begin
            ub[0] = {4'b1110, cp[15:12]};
            ub[1] = {2'b10, cp[11:6]};
            ub[2] = {2'b10, cp[5:0]};
         end
         default: begin
            ub[0] = {5'b11110, cp[20:18]};
            ub[1] = {2'b10, cp[17:12]};
            ub[2] = {2'b10, cp[11:6]};
            ub[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int k = 0; k < keep; k++) feed(ub[k]);
   endtask

   function automatic logic [20:0] valid_cp(input int len);
      case (len)
         2: return 21'($urandom_range(21'hA0, 21'h7FF));
         3: return 21'($urandom_range(0, 1) ? $urandom_range(21'h800, 21'hD7FF)
                                             : $urandom_range(21'hE000, 21'hFFFF));
         default: return 21'($urandom_range(21'h10000, 21'h10FFFF));
      endcase
   endfunction

   task automatic random_segment();
      int n;
      int len;
      logic [7:0] b;
      case ($urandom_range(0, 11))
         0, 1: begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               case ($urandom_range(0, 9))
                  0: feed(CH_LF);
                  1: feed(CH_TAB);
                  default: feed(8'($urandom_range(8'h20, 8'h7E)));
               endcase
            end
         end
         2: begin
            len = $urandom_range(2, 4);
            put_utf8(valid_cp(len), len, len);
         end
         3: begin
            case ($urandom_range(0, 5))
               0: put_utf8(21'($urandom_range(0, 21'h7FF)), 3, 3);          // overlong
               1: put_utf8(21'($urandom_range(0, 21'hFFFF)), 4, 4);         // overlong
               2: put_utf8(21'($urandom_range(21'hD800, 21'hDFFF)), 3, 3);  // surrogate
               3: put_utf8(21'($urandom_range(21'h110000, 21'h13FFFF)), 4, 4);
               4: begin
                  // cut short by a non-continuation byte
                  len = $urandom_range(3, 4);
                  put_utf8(valid_cp(len), len, $urandom_range(1, len - 1));
                  feed(8'($urandom_range(0, 1) ? $urandom_range(0, 8'h7F)
                                               : $urandom_range(8'hC0, 8'hFF)));
               end
               default: feed(8'($urandom_range(0, 1) ? $urandom_range(8'hA0, 8'hC1)
                                                     : $urandom_range(8'hF5, 8'hFF)));
            endcase
         end
         4: begin
            // C1 control in two-byte form, followed by bytes it governs
            put_utf8(21'($urandom_range(21'h80, 21'h9F)), 2, 2);
            repeat ($urandom_range(1, 3)) feed(8'($urandom_range(8'h20, 8'h7E)));
         end
         5: begin
            if ($urandom_range(0, 1)) begin
               feed(CH_ESC);
               feed("[");
            end else begin
               feed(C1_CSI);
            end
            repeat ($urandom_range(0, 4)) feed(8'($urandom_range(8'h20, 8'h3F)));
            feed(8'($urandom_range(8'h40, 8'h7E)));
         end
         6: begin
            case ($urandom_range(0, 7))
               0: begin feed(CH_ESC); feed("]"); end
               1: begin feed(CH_ESC); feed("P"); end
               2: begin feed(CH_ESC); feed("^"); end
               3: begin feed(CH_ESC); feed("_"); end
               4: feed(C1_DCS);
               5: feed(C1_OSC);
               6: feed(C1_PM);
               default: feed(C1_APC);
            endcase
            n = $urandom_range(0, 6);
            repeat (n) begin
               case ($urandom_range(0, 7))
                  0: feed(CH_LF);
                  1: feed(CH_TAB);
                  2: feed(8'($urandom_range(8'hA0, 8'hFF)));
                  default: feed(8'($urandom_range(8'h20, 8'h7E)));
               endcase
            end
            case ($urandom_range(0, 4))
               0: feed(CH_BEL);
               1: begin feed(CH_ESC); feed(CH_BSL); end
               2: feed(C1_ST);
               3: feed(CH_CAN);
               default: begin
                  feed(CH_ESC);
                  feed(8'($urandom_range(8'h20, 8'h7E)));
                  feed(CH_BEL);
               end
            endcase
         end
         7: begin
            feed(CH_ESC);
            if ($urandom_range(0, 1)) begin
               case ($urandom_range(0, 11))
                  0: b = "N";
                  1: b = "O";
                  2: b = "#";
                  3: b = "%";
                  4: b = " ";
                  5: b = "(";
                  6: b = ")";
                  7: b = "*";
                  8: b = "+";
                  9: b = "-";
                  10: b = ".";
                  default: b = "/";
               endcase
               feed(b);
            end else begin
               feed(8'($urandom_range(8'h20, 8'h7E)));
            end
            feed(8'($urandom_range(8'h20, 8'h7E)));
         end
         8: begin
            feed(8'($urandom_range(8'h80, 8'h9F)));
            feed(8'($urandom_range(8'h20, 8'h7E)));
         end
         9: begin
            feed($urandom_range(0, 1) ? 8'($urandom_range(0, 8'h1F)) : CH_DEL);
            feed(8'($urandom_range(8'h20, 8'h7E)));
         end
         default: repeat ($urandom_range(1, 4)) feed(8'($urandom_range(0, 8'hFF)));
      endcase
   endtask

   initial begin : stimulus
      int phase_start;
      bit paused;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      directed_rows.push_back('{8'h41, CHK_ONE, 8'h41});
      directed_rows.push_back('{8'h00, CHK_NONE, 8'h00});
      directed_rows.push_back('{8'h7E, CHK_ONE, 8'h7E});
      directed_rows.push_back('{CH_DEL, CHK_NONE, 8'h00});
      directed_rows.push_back('{CH_LF, CHK_ONE, CH_LF});
      directed_rows.push_back('{CH_TAB, CHK_ONE, CH_TAB});
      // CSI with one parameter
      directed_rows.push_back('{CH_ESC, CHK_NONE, 8'h00});
      directed_rows.push_back('{"[", CHK_NONE, 8'h00});
      directed_rows.push_back('{"1", CHK_NONE, 8'h00});
      directed_rows.push_back('{"m", CHK_NONE, 8'h00});
      directed_rows.push_back('{8'hC3, CHK_MODEL, 8'h00});
      directed_rows.push_back('{8'hA9, CHK_MODEL, 8'h00});
      // highest code point
      directed_rows.push_back('{8'hF4, CHK_MODEL, 8'h00});
      directed_rows.push_back('{8'h8F, CHK_MODEL, 8'h00});
      directed_rows.push_back('{8'hBF, CHK_MODEL, 8'h00});
      directed_rows.push_back('{8'hBF, CHK_MODEL, 8'h00});
      // surrogate
      directed_rows.push_back('{8'hED, CHK_MODEL, 8'h00});
      directed_rows.push_back('{8'hA0, CHK_MODEL, 8'h00});
      directed_rows.push_back('{8'h80, CHK_MODEL, 8'h00});
      // encoded CSI, then its final byte
      directed_rows.push_back('{8'hC2, CHK_MODEL, 8'h00});
      directed_rows.push_back('{8'h9B, CHK_MODEL, 8'h00});
      directed_rows.push_back('{8'h41, CHK_MODEL, 8'h00});
      // lead byte then plain ASCII
      directed_rows.push_back('{8'hC3, CHK_MODEL, 8'h00});
      directed_rows.push_back('{8'h41, CHK_MODEL, 8'h00});
      // OSC swallowing a newline, ended by BEL
      directed_rows.push_back('{C1_OSC, CHK_MODEL, 8'h00});
      directed_rows.push_back('{CH_LF, CHK_NONE, 8'h00});
      directed_rows.push_back('{CH_BEL, CHK_NONE, 8'h00});
      directed_rows.push_back('{8'hFF, CHK_NONE, 8'h00});

      foreach (directed_rows[i])
         send(directed_rows[i].data, directed_rows[i].chk, directed_rows[i].out);
      directed_count = fed;
      wait_drained();

      // receiver holds off while plain text streams in back to back
      hold_now = 1'b1;
      no_idle = 1'b1;
      repeat (HOLD_ITEMS) feed(8'($urandom_range(8'h20, 8'h7E)));
      no_idle = 1'b0;

      phase_start = fed;
      paused = 1'b0;
      while (fed - phase_start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 5) == 0) no_idle = !no_idle;
         if (!paused && fed - phase_start >= RANDOM_ITEMS / 2) begin
            paused = 1'b1;
            wait_drained();
         end
         random_segment();
      end
      no_idle = 1'b0;

      wait_drained();
      repeat (40) @(posedge clock);
      if (text_q.size() != 0) begin
         $error("%0d expected words never arrived", text_q.size());
         mismatches++;
      end
      $display("fed %0d bytes: %0d directed, %0d against a stalled output, rest random",
               fed, directed_count, HOLD_ITEMS);
      $display("checked %0d text words, %0d mismatches", words_checked, mismatches);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   initial begin : receiver
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, GAP_MAX);
         if (hold_now) begin
            hold_now = 1'b0;
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

endmodule

### sim.f
sv/tesan_pkg.sv
sv/tesan_front.sv
sv/tesan_queue.sv
sv/tesan_back.sv
sv/terminal_escape_utf8_sanitizer.sv
sim/tb_terminal_escape_utf8_sanitizer.sv
